@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_DATA    = 2'd0;
	localparam status_t ST_END     = 2'd1;
	localparam status_t ST_BAD_SUM = 2'd2;
	localparam status_t ST_EMPTY   = 2'd3;

	// configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_END    = 2'd1;
	localparam logic [1:0] REG_ESCAPE = 2'd2;

	localparam logic [7:0] START_RESET  = 8'hAA;
	localparam logic [7:0] END_RESET    = 8'h55;
	localparam logic [7:0] ESCAPE_RESET = 8'h7D;

	// escape codes and the bytes they stand for
	localparam logic [7:0] ESC_CODE_AA = 8'h01;
	localparam logic [7:0] ESC_CODE_55 = 8'h02;
	localparam logic [7:0] ESC_CODE_7D = 8'h03;
	localparam logic [7:0] ESC_VAL_AA  = 8'hAA;
	localparam logic [7:0] ESC_VAL_55  = 8'h55;
	localparam logic [7:0] ESC_VAL_7D  = 8'h7D;

	typedef struct packed {
		logic       ok;
		logic [7:0] value;
	} esc_map_t;

	function automatic esc_map_t esc_map(input logic [7:0] code);
		esc_map_t r;
		r.ok    = 1'b1;
		r.value = 8'h00;
		unique case (code)
			ESC_CODE_AA: r.value = ESC_VAL_AA;
			ESC_CODE_55: r.value = ESC_VAL_55;
			ESC_CODE_7D: r.value = ESC_VAL_7D;
			default:     r.ok    = 1'b0;
		endcase
		return r;
	endfunction

	// controller -> datapath
	typedef struct packed {
		logic    clear;       // open a new frame
		logic    wr_store;    // store a byte
		logic    wr_sel_esc;  // stored byte is the decoded escape
		logic    rd_clear;    // rewind drain index
		logic    rd_issue;    // read store at drain index
		logic    rd_next;     // advance drain index
		logic    load_data;   // load payload result
		logic    load_fin;    // load final result
		status_t fin_code;
	} sfr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_start;
		logic is_esc;
		logic is_end;
		logic esc_ok;
		logic full;
		logic fill_zero;
		logic one_byte;
		logic xor_zero;
		logic last_payload;
		logic slot_free;
	} sfr_sts_t;

endpackage

@@ rtl/sfr_ram.sv @@
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/sfr_ctrl.sv @@
module sfr_ctrl import sfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  sfr_sts_t sts,
	output sfr_cmd_t cmd
);

	localparam logic [2:0] S_WAIT = 3'd0;
	localparam logic [2:0] S_RECV = 3'd1;
	localparam logic [2:0] S_ESC  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q, state_d;
	status_t    fin_q, fin_d;
	logic       take;

	assign in_stall = !(state_q == S_WAIT || state_q == S_RECV || state_q == S_ESC);
	assign take     = in_valid && !in_stall;

	always_comb begin
		state_d  = state_q;
		fin_d    = fin_q;
		cmd      = '0;
		cmd.fin_code = fin_q;
		unique case (state_q)
			S_WAIT: begin
				if (take && sts.is_start) begin
					cmd.clear = 1'b1;
					state_d   = S_RECV;
				end
			end
			S_RECV: begin
				if (take) begin
					priority if (sts.is_esc) begin
						state_d = S_ESC;
					end else if (sts.is_end) begin
						priority if (sts.fill_zero) begin
							fin_d   = ST_EMPTY;
							state_d = S_FIN;
						end else if (!sts.xor_zero) begin
							fin_d   = ST_BAD_SUM;
							state_d = S_FIN;
						end else if (sts.one_byte) begin
							fin_d   = ST_END;
							state_d = S_FIN;
						end else begin
							cmd.rd_clear = 1'b1;
							state_d      = S_RD;
						end
					end else if (sts.full) begin
						state_d = S_WAIT;
					end else begin
						cmd.wr_store = 1'b1;
					end
				end
			end
			S_ESC: begin
				if (take) begin
					if (sts.esc_ok && !sts.full) begin
						cmd.wr_store   = 1'b1;
						cmd.wr_sel_esc = 1'b1;
						state_d        = S_RECV;
					end else begin
						state_d = S_WAIT;
					end
				end
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_WR;
			end
			S_WR: begin
				if (sts.slot_free) begin
					cmd.load_data = 1'b1;
					if (sts.last_payload) begin
						fin_d   = ST_END;
						state_d = S_FIN;
					end else begin
						cmd.rd_next = 1'b1;
						state_d     = S_RD;
					end
				end
			end
			S_FIN: begin
				if (sts.slot_free) begin
					cmd.load_fin = 1'b1;
					state_d      = S_WAIT;
				end
			end
			default: state_d = S_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WAIT;
			fin_q   <= ST_END;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
		end
	end

endmodule

@@ rtl/sfr_dp.sv @@
module sfr_dp import sfr_pkg::*; #(
	parameter int STORE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        out_stall,
	output logic        out_valid,
	output status_t     status,
	output logic [7:0]  data,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	output logic [31:0] cfg_rdata,
	input  sfr_cmd_t    cmd,
	output sfr_sts_t    sts
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int FW = $clog2(STORE_DEPTH + 1);

	logic [7:0]    start_q, end_q, escape_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    xor_q;
	logic [AW-1:0] rd_idx_q;
	logic [7:0]    ram_rdata;
	logic [7:0]    wr_byte;
	esc_map_t      esc;

	assign esc     = esc_map(rx_byte);
	assign wr_byte = cmd.wr_sel_esc ? esc.value : rx_byte;

	always_comb begin
		sts.is_start     = rx_byte == start_q;
		sts.is_esc       = rx_byte == escape_q;
		sts.is_end       = rx_byte == end_q;
		sts.esc_ok       = esc.ok;
		sts.full         = fill_q == FW'(STORE_DEPTH);
		sts.fill_zero    = fill_q == '0;
		sts.one_byte     = fill_q == FW'(1);
		sts.xor_zero     = xor_q == 8'h00;
		sts.last_payload = (FW'(rd_idx_q) + FW'(2)) == fill_q;
		sts.slot_free    = !out_valid || !out_stall;
	end

	always_comb begin
		unique case (cfg_idx)
			REG_START:  cfg_rdata = {24'd0, start_q};
			REG_END:    cfg_rdata = {24'd0, end_q};
			REG_ESCAPE: cfg_rdata = {24'd0, escape_q};
			default:    cfg_rdata = 32'd0;
		endcase
	end

	sfr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (cmd.wr_store),
		.waddr (fill_q[AW-1:0]),
		.wdata (wr_byte),
		.re    (cmd.rd_issue),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_RESET;
			end_q    <= END_RESET;
			escape_q <= ESCAPE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_START:  start_q  <= cfg_wdata[7:0];
				REG_END:    end_q    <= cfg_wdata[7:0];
				REG_ESCAPE: escape_q <= cfg_wdata[7:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			xor_q  <= 8'h00;
		end else if (cmd.clear) begin
			fill_q <= '0;
			xor_q  <= 8'h00;
		end else if (cmd.wr_store) begin
			fill_q <= fill_q + FW'(1);
			xor_q  <= xor_q ^ wr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_clear) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_next) begin
			rd_idx_q <= rd_idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_data || cmd.load_fin) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_data) begin
			status <= ST_DATA;
			data   <= ram_rdata;
			last   <= 1'b0;
		end else if (cmd.load_fin) begin
			status <= cmd.fin_code;
			data   <= 8'h00;
			last   <= 1'b1;
		end
	end

endmodule

@@ rtl/stuffed_frame_receiver_xor_check_core.sv @@
// Sequence: after an end byte is taken, a payload result is read from the store
//   (S_RD), then loaded to the output register (S_WR); a single final result loads from S_FIN.
// Throughput: one line byte per cycle while receiving; the payload drain alternates a
//   store read and an output load on the single read port, holding while the output stalls.
// Reset: asynchronous, active low; registers return to AA/55/7D, waiting for start.
module stuffed_frame_receiver_xor_check_core import sfr_pkg::*; #(
	parameter int STORE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// line byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  data,
	output logic        last,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sfr_cmd_t cmd;
	sfr_sts_t sts;
	logic     cfg_we;

	// Registers sit on word addresses; the write lands in the access cycle.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	// Controller: frame mode, drain sequencing, final result code.
	sfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: config registers, frame store, fill count, running XOR, output register.
	sfr_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.status    (status),
		.data      (data),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_idx   (paddr[3:2]),
		.cfg_wdata (pwdata),
		.cfg_rdata (prdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Only one of clear, store write or result load per cycle.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.wr_store, cmd.load_data, cmd.load_fin}))
		else $error("more than one datapath action in a cycle");

	// Never overwrite a result that is still held by the sink.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_data || cmd.load_fin) |-> !(out_valid && out_stall))
		else $error("result register loaded while stalled");

	// Never write past the end of the store.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_store |-> !sts.full)
		else $error("store write while full");

	// Non-payload results carry zero data and close the run.
	a_fin_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DATA) |-> (data == 8'h00 && last))
		else $error("final result malformed");

endmodule
